// ===== hdl/text_console_cell_writer_macros.svh =====
// Assertion macros used by the checker of the console cell writer.
`ifndef TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_MACROS_SVH

// Check on every clock edge outside reset.
`define TCCW_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("console cell writer check failed");

// Check on every clock edge, reset included.
`define TCCW_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("console cell writer check failed");

`endif

// ===== hdl/tccw_pkg.sv =====
package tccw_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int TAB_SPACES    = 4;

    localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W = 11;
    localparam int COL_W  = $clog2(SCREEN_WIDTH);
    localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
    localparam int TCOL_W = 7;
    localparam int TROW_W = 5;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [7:0]        t_char;
    typedef logic [15:0]       t_word;
    typedef logic [3:0]        t_color;

    typedef enum logic [2:0] {
        REQ_PUT    = 3'd0,
        REQ_ERASE  = 3'd1,
        REQ_BERASE = 3'd2,
        REQ_GOTO   = 3'd3,
        REQ_CLEAR  = 3'd4
    } t_req_type;

    typedef enum logic [0:0] {
        CFG_FORE = 1'b0,
        CFG_BACK = 1'b1
    } t_cfg_idx;

    localparam t_char CH_NUL   = 8'h00;
    localparam t_char CH_TAB   = 8'h09;
    localparam t_char CH_LF    = 8'h0A;
    localparam t_char CH_SPACE = 8'h20;

    localparam t_color FORE_RESET = 4'hF;
    localparam t_color BACK_RESET = 4'h0;

    typedef struct packed {
        logic [2:0]        req_type;
        t_char             char_code;
        t_char             erase_bound;
        logic [TCOL_W-1:0] target_col;
        logic [TROW_W-1:0] target_row;
    } t_req;

    typedef struct packed {
        logic  cell_write;
        t_addr cell_address;
        t_word cell_word;
        logic  clear_screen;
        t_addr cursor_position;
        logic  last;
    } t_res;

    typedef struct packed {
        logic emit;
        logic fin;
    } t_step;

endpackage

// ===== hdl/tccw_req_if.sv =====
interface tccw_req_if;
    import tccw_pkg::*;

    logic              valid;
    logic              ready;
    logic [2:0]        req_type;
    t_char             char_code;
    t_char             erase_bound;
    logic [TCOL_W-1:0] target_col;
    logic [TROW_W-1:0] target_row;

    modport source (
        output valid, req_type, char_code, erase_bound, target_col, target_row,
        input  ready
    );
    modport sink (
        input  valid, req_type, char_code, erase_bound, target_col, target_row,
        output ready
    );
endinterface

// ===== hdl/tccw_res_if.sv =====
interface tccw_res_if;
    import tccw_pkg::*;

    logic  valid;
    logic  ready;
    logic  cell_write;
    t_addr cell_address;
    t_word cell_word;
    logic  clear_screen;
    t_addr cursor_position;
    logic  last;

    modport source (
        output valid, cell_write, cell_address, cell_word, clear_screen,
               cursor_position, last,
        input  ready
    );
    modport sink (
        input  valid, cell_write, cell_address, cell_word, clear_screen,
               cursor_position, last,
        output ready
    );
endinterface

// ===== hdl/text_console_cell_writer.sv =====
// A request is registered into r_req, the sequencer computes its step, and each result
// is registered into r_res. Throughput: one result per cycle while o_res.ready does not
// stall it; a request holds the sequencer until its last step, a tab for TAB_SPACES spaces.
// The next request is taken in the cycle its predecessor issues its last result.
// Reset (i_rst_n low at a clock edge): position goes to cell 0, colors to 15 / 0,
// pending requests and results are dropped.
module text_console_cell_writer #(
    parameter int TAB_SPACES = tccw_pkg::TAB_SPACES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    tccw_req_if.sink               i_req,
    tccw_res_if.source             o_res,
    input  logic                   i_cfg_we,
    input  logic [0:0]             i_cfg_idx,
    input  tccw_pkg::t_color       i_cfg_data
);
    import tccw_pkg::*;

    t_req   r_req;
    logic   r_busy;
    t_res   r_res;
    logic   r_out_valid;
    t_color r_fore;
    t_color r_back;

    t_step step;
    t_res  res;
    logic  adv;
    logic  take;

    tccw_seq #(
        .TAB_SPACES (TAB_SPACES)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .i_adv   (adv),
        .i_fore  (r_fore),
        .i_back  (r_back),
        .o_step  (step),
        .o_res   (res)
    );

    assign adv         = r_busy && (!step.emit || !r_out_valid || o_res.ready);
    assign i_req.ready = !r_busy || (adv && step.fin);
    assign take        = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (take) begin
            r_busy <= 1'b1;
        end else if (adv && step.fin) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req.req_type    <= i_req.req_type;
            r_req.char_code   <= i_req.char_code;
            r_req.erase_bound <= i_req.erase_bound;
            r_req.target_col  <= i_req.target_col;
            r_req.target_row  <= i_req.target_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && step.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && step.emit) begin
            r_res <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fore <= FORE_RESET;
            r_back <= BACK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FORE: r_fore <= i_cfg_data;
                CFG_BACK: r_back <= i_cfg_data;
                default:  r_fore <= r_fore;
            endcase
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.cell_write      = r_res.cell_write;
    assign o_res.cell_address    = r_res.cell_address;
    assign o_res.cell_word       = r_res.cell_word;
    assign o_res.clear_screen    = r_res.clear_screen;
    assign o_res.cursor_position = r_res.cursor_position;
    assign o_res.last            = r_res.last;
endmodule

// ===== hdl/tccw_seq.sv =====
module tccw_seq #(
    parameter int TAB_SPACES = tccw_pkg::TAB_SPACES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tccw_pkg::t_req   i_req,
    input  logic            i_adv,
    input  tccw_pkg::t_color i_fore,
    input  tccw_pkg::t_color i_back,
    output tccw_pkg::t_step  o_step,
    output tccw_pkg::t_res   o_res
);
    import tccw_pkg::*;

    localparam int STEP_W = $clog2(TAB_SPACES + 2);

    t_addr             r_idx, n_idx;
    t_col              r_col, n_col;
    t_row              r_row, n_row;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_pend, n_pend;

    logic  do_clear;
    logic  erase_act;
    t_word blank;
    t_char put_ch;

    always_comb begin
        blank     = {i_back, i_fore, CH_NUL};
        put_ch    = (i_req.char_code == CH_TAB) ? CH_SPACE : i_req.char_code;
        erase_act = (i_req.req_type == REQ_ERASE) ||
                    ((i_req.erase_bound != CH_NUL) && (8'(r_col) > i_req.erase_bound));
        n_idx     = r_idx;
        n_col     = r_col;
        n_row     = r_row;
        n_step    = '0;
        n_pend    = 1'b0;
        do_clear  = 1'b0;
        o_step.emit = 1'b1;
        o_step.fin  = 1'b1;
        o_res.cell_write   = 1'b0;
        o_res.cell_address = '0;
        o_res.cell_word    = '0;
        o_res.clear_screen = 1'b0;

        unique case (i_req.req_type) inside
            REQ_PUT: begin
                if (i_req.char_code == CH_NUL) begin
                    o_step.emit = 1'b0;
                end else if (i_req.char_code == CH_LF) begin
                    if (r_row >= ROW_W'(SCREEN_HEIGHT - 1)) begin
                        do_clear = 1'b1;
                    end else begin
                        n_row = r_row + ROW_W'(1);
                        n_col = '0;
                        n_idx = ADDR_W'(n_row) * ADDR_W'(SCREEN_WIDTH);
                    end
                end else if (r_pend) begin
                    do_clear = 1'b1;
                end else begin
                    o_res.cell_write   = 1'b1;
                    o_res.cell_address = r_idx;
                    o_res.cell_word    = {i_back, i_fore, put_ch};
                    n_idx = r_idx + ADDR_W'(1);
                    if (r_col == COL_W'(SCREEN_WIDTH - 1)) begin
                        n_col = '0;
                        n_row = r_row + ROW_W'(1);
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                    if (n_idx == ADDR_W'(CELLS)) begin
                        n_pend     = 1'b1;
                        o_step.fin = 1'b0;
                    end else if ((i_req.char_code == CH_TAB) &&
                                 (r_step != STEP_W'(TAB_SPACES - 1))) begin
                        n_step     = r_step + STEP_W'(1);
                        o_step.fin = 1'b0;
                    end
                end
            end
            REQ_ERASE, REQ_BERASE: begin
                o_res.cell_write = 1'b1;
                o_res.cell_word  = blank;
                if (r_step == '0) begin
                    o_res.cell_address = r_idx;
                    if (erase_act && (r_idx != '0)) begin
                        n_step     = STEP_W'(1);
                        o_step.fin = 1'b0;
                    end
                end else begin
                    n_idx = r_idx - ADDR_W'(1);
                    if (r_col == '0) begin
                        n_col = COL_W'(SCREEN_WIDTH - 1);
                        n_row = r_row - ROW_W'(1);
                    end else begin
                        n_col = r_col - COL_W'(1);
                    end
                    o_res.cell_address = n_idx;
                end
            end
            REQ_GOTO: begin
                if (i_req.target_col > TCOL_W'(SCREEN_WIDTH - 1)) begin
                    n_col = COL_W'(SCREEN_WIDTH - 1);
                end else begin
                    n_col = i_req.target_col[COL_W-1:0];
                end
                if (i_req.target_row > TROW_W'(SCREEN_HEIGHT - 1)) begin
                    n_row = ROW_W'(SCREEN_HEIGHT - 1);
                end else begin
                    n_row = i_req.target_row[ROW_W-1:0];
                end
                n_idx = ADDR_W'(n_row) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(n_col);
            end
            REQ_CLEAR: begin
                do_clear = 1'b1;
            end
            default: begin
                o_step.emit = 1'b0;
            end
        endcase

        if (do_clear) begin
            n_idx  = '0;
            n_col  = '0;
            n_row  = '0;
            n_step = '0;
            n_pend = 1'b0;
            o_res.clear_screen = 1'b1;
            o_res.cell_word    = blank;
        end

        o_res.cursor_position = n_idx;
        o_res.last            = o_step.fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_col  <= '0;
            r_row  <= '0;
            r_step <= '0;
            r_pend <= 1'b0;
        end else if (i_adv) begin
            r_idx  <= n_idx;
            r_col  <= n_col;
            r_row  <= n_row;
            r_step <= n_step;
            r_pend <= n_pend;
        end
    end
endmodule

// ===== hdl/tccw_checker.sv =====
`include "text_console_cell_writer_macros.svh"

module tccw_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic                i_cell_write,
    input tccw_pkg::t_addr      i_cell_address,
    input tccw_pkg::t_word      i_cell_word,
    input logic                i_clear_screen,
    input tccw_pkg::t_addr      i_cursor_position,
    input logic                i_last
);
    import tccw_pkg::*;

    `TCCW_ASSERT_ALWAYS(a_reset_drops_result, !i_rst_n |=> !i_out_valid)
    `TCCW_ASSERT(a_result_holds, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_cursor_position) && $stable(i_cell_word))
    `TCCW_ASSERT(a_clear_ends_request, i_out_valid && i_clear_screen |-> !i_cell_write && i_last && (i_cursor_position == '0))
    `TCCW_ASSERT(a_cursor_only_result, i_out_valid && !i_cell_write && !i_clear_screen |-> i_last && (i_cell_word == '0) && (i_cell_address == '0))
endmodule

bind text_console_cell_writer tccw_checker u_tccw_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_res.valid),
    .i_out_ready       (o_res.ready),
    .i_cell_write      (o_res.cell_write),
    .i_cell_address    (o_res.cell_address),
    .i_cell_word       (o_res.cell_word),
    .i_clear_screen    (o_res.clear_screen),
    .i_cursor_position (o_res.cursor_position),
    .i_last            (o_res.last)
);
